// ===== rtl/ogru_pkg.sv =====
package ogru_pkg;

  localparam int GRID_SIZE_DEF   = 256;
  localparam int OCC_WIDTH_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int POINT_W  = 16;
  localparam int POSE_W   = 24;
  localparam int TRIG_W   = 16;
  localparam int CS_W     = 10;
  localparam int THR_W    = 16;
  localparam int STATUS_W = 2;
  localparam int END_W    = 8;
  localparam int WALK_W   = 9;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // q14 fraction bits of the trig values
  localparam int FRAC_W = 14;
  localparam int PROD_W = 2 * TRIG_W;
  localparam int ACC_W  = POSE_W + FRAC_W + 2;
  localparam int MM_W   = ACC_W - FRAC_W;
  localparam int DIVISOR_W = CS_W + 1;

  localparam logic [TRIG_W-1:0] COS_RESET       = 16'd16384;
  localparam logic [CS_W-1:0]   CELL_SIZE_RESET = 10'd50;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'hffff;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 2'd0,
    ST_INVALID   = 2'd1,
    ST_END_OFF   = 2'd2,
    ST_ROBOT_OFF = 2'd3
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POSE_X    = 3'd0,
    REG_POSE_Y    = 3'd1,
    REG_SIN       = 3'd2,
    REG_COS       = 3'd3,
    REG_CELL_SIZE = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/ogru_div.sv =====
module ogru_div
  import ogru_pkg::*;
#(
  parameter int MAG_W = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MAG_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [MAG_W-1:0]     quotient_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic                 run_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] div_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [MAG_W-1:0]     quo_q;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, quo_q[MAG_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        div_q <= divisor_i;
        rem_q <= '0;
        quo_q <= dividend_i;
      end else if (run_q) begin
        rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_q <= {quo_q[MAG_W-2:0], fits};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/occupancy_grid_ray_update.sv =====
// occupancy grid ray update
// command channel: a point transfers at a clock edge with start high and busy low;
// point_valid_i low skips the point and only reports a status
// one result per point: result_valid_o is high for a single cycle with status,
// endpoint cell and number of walked cells; the receiver cannot stall it
// config: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at once; the user
// must write only while busy is low, which the block itself does not enforce
// steps for a valid point: 5 multiply steps on one shared 16x16 multiplier, four
// divisions by 2*cell size on one shared restoring divider, then a decision step,
// which ends a point that falls off the grid; an updated point adds a hit count
// read-modify-write, a walk setup step and, per walked cell, a memory read and
// then a write
// one point is in work at a time; for a valid point busy stays high until its
// result is shown
// reset: after rst_ni releases, both grids are cleared one cell a cycle,
// with busy high meanwhile
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int GRID_SIZE   = GRID_SIZE_DEF,
  parameter int OCC_WIDTH   = OCC_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [POINT_W-1:0] point_x_mm_i,
  input  logic signed [POINT_W-1:0] point_y_mm_i,
  input  logic                      point_valid_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                      result_valid_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [END_W-1:0]          end_cell_x_o,
  output logic [END_W-1:0]          end_cell_y_o,
  output logic [WALK_W-1:0]         cells_walked_o
);

  localparam int IDXW  = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int GCW   = $clog2(GRID_SIZE + 1) + CS_W;
  localparam int NW    = ((GCW > MM_W + 1) ? GCW : MM_W + 1) + 1;
  localparam int MAG_W = NW;
  localparam int SW    = ((OCC_WIDTH > COUNT_WIDTH) ? OCC_WIDTH : COUNT_WIDTH) + 2;
  localparam int HW    = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  localparam logic signed [SW-1:0] OCC_MAX  = {{(SW-OCC_WIDTH+1){1'b0}}, {(OCC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] OCC_MIN  = ~OCC_MAX;
  localparam logic signed [SW-1:0] INC_END  = SW'(2);
  localparam logic signed [SW-1:0] DEC_WALK = -SW'(1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic signed [ACC_W-1:0] ROUND_NEG = ACC_W'((1 << FRAC_W) - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_DPREP, S_DGO, S_DWAIT, S_DECIDE,
    S_HRD, S_HWR, S_WSETUP, S_WSTEP, S_WUPD
  } state_e;

  state_e state_q;

  logic signed [POSE_W-1:0] pose_x_q, pose_y_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;
  logic [CS_W-1:0]          cs_q;
  logic [THR_W-1:0]         thr_q;

  logic [AW-1:0]             clr_q;
  logic signed [POINT_W-1:0] px_q, py_q;
  logic [2:0]                mstep_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   accx_q, accy_q;
  logic [1:0]                dsel_q;
  logic signed [NW-1:0]      n_q;
  logic [IDXW-1:0]           idx_q [4];
  logic [3:0]                ok_q;

  logic            sxn_q, syn_q, xmaj_q;
  logic [IDXW-1:0] major_q, minor_q, k_q, l_q, i_q;
  logic [IDXW:0]   e_q;

  logic                result_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [END_W-1:0]    end_x_q, end_y_q;
  logic [WALK_W-1:0]   walked_q;

  logic signed [OCC_WIDTH-1:0] occ_mem [CELLS];
  logic [COUNT_WIDTH-1:0]      hit_mem [CELLS];
  logic signed [OCC_WIDTH-1:0] occ_rd_q;
  logic [COUNT_WIDTH-1:0]      hit_rd_q;

  logic [AW-1:0]               mem_addr;
  logic                        occ_we, hit_we;
  logic signed [OCC_WIDTH-1:0] occ_wdata;
  logic [COUNT_WIDTH-1:0]      hit_wdata;

  logic signed [TRIG_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   acc_sel, acc_rnd;
  logic signed [MM_W-1:0]    m_sel;
  logic [CS_W-1:0]           cs_eff;
  logic [GCW-1:0]            gc;
  logic signed [NW-1:0]      n_d;
  logic [MAG_W-1:0]          mag;
  logic                      div_start, div_done;
  logic [MAG_W-1:0]          div_quo;
  logic                      q_neg, q_ok;
  logic [IDXW-1:0]           q_idx;

  logic signed [IDXW:0] dx, dy;
  logic [IDXW-1:0]      ax, ay;
  logic [IDXW-1:0]      stepx, stepy;
  logic [IDXW:0]        e_sum, e_next;
  logic                 adv;
  logic [IDXW-1:0]      k_adj, l_adj;
  logic                 last;

  logic signed [SW-1:0] o1, o1s, o2, o_new;
  logic                 merge;

  function automatic logic [AW-1:0] cell_addr(input logic [IDXW-1:0] x,
                                               input logic [IDXW-1:0] y);
    cell_addr = AW'(AW'(x) * AW'(GRID_SIZE) + AW'(y));
  endfunction

  function automatic logic signed [SW-1:0] sat_occ(input logic signed [SW-1:0] v);
    if (v > OCC_MAX) begin
      sat_occ = OCC_MAX;
    end else if (v < OCC_MIN) begin
      sat_occ = OCC_MIN;
    end else begin
      sat_occ = v;
    end
  endfunction

  // shared multiplier operands
  always_comb begin
    unique case (mstep_q)
      3'd1:    begin mul_a = py_q; mul_b = sin_q; end
      3'd2:    begin mul_a = px_q; mul_b = sin_q; end
      3'd3:    begin mul_a = py_q; mul_b = cos_q; end
      default: begin mul_a = px_q; mul_b = cos_q; end
    endcase
    prod_d = mul_a * mul_b;
  end

  // millimetres to the dividend of the cell index
  always_comb begin
    acc_sel = dsel_q[0] ? accy_q : accx_q;
    acc_rnd = acc_sel + (acc_sel[ACC_W-1] ? ROUND_NEG : '0);
    unique case (dsel_q)
      2'd2:    m_sel = MM_W'(pose_x_q);
      2'd3:    m_sel = MM_W'(pose_y_q);
      default: m_sel = acc_rnd[ACC_W-1:FRAC_W];
    endcase
    cs_eff = (cs_q == '0) ? CS_W'(1) : cs_q;
    gc     = GCW'(GRID_SIZE) * GCW'(cs_eff);
    n_d    = NW'(signed'({1'b0, gc})) - (NW'(m_sel) <<< 1);
    mag    = n_q[NW-1] ? MAG_W'(-n_q) : MAG_W'(n_q);
    q_neg  = n_q[NW-1];
    q_ok   = q_neg ? (div_quo == '0) : (div_quo < MAG_W'(GRID_SIZE));
    q_idx  = q_neg ? '0 : div_quo[IDXW-1:0];
  end

  ogru_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  ({cs_eff, 1'b0}),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign div_start = (state_q == S_DGO);

  // line walk
  always_comb begin
    dx     = signed'({1'b0, idx_q[0]}) - signed'({1'b0, idx_q[2]});
    dy     = signed'({1'b0, idx_q[1]}) - signed'({1'b0, idx_q[3]});
    ax     = dx[IDXW] ? IDXW'(-dx) : IDXW'(dx);
    ay     = dy[IDXW] ? IDXW'(-dy) : IDXW'(dy);
    stepx  = sxn_q ? '1 : IDXW'(1);
    stepy  = syn_q ? '1 : IDXW'(1);
    e_sum  = e_q + (IDXW+1)'(minor_q);
    adv    = e_sum > (IDXW+1)'(major_q);
    e_next = adv ? e_sum - (IDXW+1)'(major_q) : e_sum;
    k_adj  = (adv && !xmaj_q) ? k_q + stepx : k_q;
    l_adj  = (adv && xmaj_q) ? l_q + stepy : l_q;
    last   = (i_q == major_q);
  end

  // cell update
  always_comb begin
    o1    = sat_occ(SW'(occ_rd_q) + (last ? INC_END : DEC_WALK));
    o1s   = o1;
    o2    = o1s + signed'(SW'(hit_rd_q));
    merge = (HW'(hit_rd_q) > HW'(thr_q)) && (o1s < 0) && (o2 > 0);
    o_new = merge ? sat_occ(o2) : o1s;
  end

  // memory port control
  always_comb begin
    mem_addr  = cell_addr(k_q, l_q);
    occ_we    = 1'b0;
    hit_we    = 1'b0;
    occ_wdata = OCC_WIDTH'(o_new);
    hit_wdata = (hit_rd_q == COUNT_MAX) ? hit_rd_q : hit_rd_q + COUNT_WIDTH'(1);
    unique case (state_q)
      S_CLEAR: begin
        mem_addr  = clr_q;
        occ_we    = 1'b1;
        hit_we    = 1'b1;
        occ_wdata = '0;
        hit_wdata = '0;
      end
      S_HRD:   mem_addr = cell_addr(idx_q[0], idx_q[1]);
      S_HWR: begin
        mem_addr = cell_addr(idx_q[0], idx_q[1]);
        hit_we   = 1'b1;
      end
      S_WSTEP: mem_addr = cell_addr(k_adj, l_adj);
      S_WUPD:  occ_we = 1'b1;
      default: mem_addr = cell_addr(k_q, l_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[mem_addr] <= occ_wdata;
    end
    if (hit_we) begin
      hit_mem[mem_addr] <= hit_wdata;
    end
    occ_rd_q <= occ_mem[mem_addr];
    hit_rd_q <= hit_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      pose_x_q       <= '0;
      pose_y_q       <= '0;
      sin_q          <= '0;
      cos_q          <= COS_RESET;
      cs_q           <= CELL_SIZE_RESET;
      thr_q          <= THRESHOLD_RESET;
      clr_q          <= '0;
      px_q           <= '0;
      py_q           <= '0;
      mstep_q        <= '0;
      prod_q         <= '0;
      accx_q         <= '0;
      accy_q         <= '0;
      dsel_q         <= '0;
      n_q            <= '0;
      idx_q          <= '{default: '0};
      ok_q           <= '0;
      sxn_q          <= 1'b0;
      syn_q          <= 1'b0;
      xmaj_q         <= 1'b0;
      major_q        <= '0;
      minor_q        <= '0;
      k_q            <= '0;
      l_q            <= '0;
      i_q            <= '0;
      e_q            <= '0;
      result_valid_q <= 1'b0;
      status_q       <= '0;
      end_x_q        <= '0;
      end_y_q        <= '0;
      walked_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_POSE_X:    pose_x_q <= cfg_wdata_i[POSE_W-1:0];
          REG_POSE_Y:    pose_y_q <= cfg_wdata_i[POSE_W-1:0];
          REG_SIN:       sin_q    <= cfg_wdata_i[TRIG_W-1:0];
          REG_COS:       cos_q    <= cfg_wdata_i[TRIG_W-1:0];
          REG_CELL_SIZE: cs_q     <= cfg_wdata_i[CS_W-1:0];
          REG_THRESHOLD: thr_q    <= cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            px_q <= point_x_mm_i;
            py_q <= point_y_mm_i;
            if (!point_valid_i) begin
              result_valid_q <= 1'b1;
              status_q       <= ST_INVALID;
              end_x_q        <= '0;
              end_y_q        <= '0;
              walked_q       <= '0;
            end else begin
              mstep_q <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= prod_d;
          mstep_q <= mstep_q + 3'd1;
          unique case (mstep_q)
            3'd0: accx_q <= ACC_W'(pose_x_q) <<< FRAC_W;
            3'd1: accx_q <= accx_q + ACC_W'(prod_q);
            3'd2: begin
              accx_q <= accx_q - ACC_W'(prod_q);
              accy_q <= ACC_W'(pose_y_q) <<< FRAC_W;
            end
            3'd3: accy_q <= accy_q + ACC_W'(prod_q);
            default: begin
              accy_q  <= accy_q + ACC_W'(prod_q);
              dsel_q  <= '0;
              state_q <= S_DPREP;
            end
          endcase
        end
        S_DPREP: begin
          n_q     <= n_d;
          state_q <= S_DGO;
        end
        S_DGO: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            idx_q[dsel_q] <= q_idx;
            ok_q[dsel_q]  <= q_ok;
            dsel_q        <= dsel_q + 2'd1;
            state_q       <= (dsel_q == 2'd3) ? S_DECIDE : S_DPREP;
          end
        end
        S_DECIDE: begin
          if (!(ok_q[0] && ok_q[1])) begin
            result_valid_q <= 1'b1;
            status_q       <= ST_END_OFF;
            end_x_q        <= '0;
            end_y_q        <= '0;
            walked_q       <= '0;
            state_q        <= S_IDLE;
          end else if (!(ok_q[2] && ok_q[3])) begin
            result_valid_q <= 1'b1;
            status_q       <= ST_ROBOT_OFF;
            end_x_q        <= END_W'(idx_q[0]);
            end_y_q        <= END_W'(idx_q[1]);
            walked_q       <= '0;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_HRD;
          end
        end
        S_HRD: state_q <= S_HWR;
        S_HWR: state_q <= S_WSETUP;
        S_WSETUP: begin
          sxn_q   <= dx[IDXW];
          syn_q   <= dy[IDXW];
          xmaj_q  <= ax > ay;
          major_q <= (ax > ay) ? ax : ay;
          minor_q <= (ax > ay) ? ay : ax;
          k_q     <= idx_q[2];
          l_q     <= idx_q[3];
          e_q     <= '0;
          i_q     <= '0;
          state_q <= S_WSTEP;
        end
        S_WSTEP: begin
          k_q     <= k_adj;
          l_q     <= l_adj;
          e_q     <= e_next;
          state_q <= S_WUPD;
        end
        S_WUPD: begin
          if (xmaj_q) begin
            k_q <= k_q + stepx;
          end else begin
            l_q <= l_q + stepy;
          end
          i_q <= i_q + IDXW'(1);
          if (last) begin
            result_valid_q <= 1'b1;
            status_q       <= ST_UPDATED;
            end_x_q        <= END_W'(idx_q[0]);
            end_y_q        <= END_W'(idx_q[1]);
            walked_q       <= WALK_W'({1'b0, major_q} + (IDXW+1)'(1));
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_WSTEP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign end_cell_x_o   = end_x_q;
  assign end_cell_y_o   = end_y_q;
  assign cells_walked_o = walked_q;

endmodule

// ===== tb/sv/tb_occupancy_grid_ray_update.sv =====
`timescale 1ns / 100ps

module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;
  localparam int GRID_CELLS = GRID * GRID;
  localparam longint OCC_MAX = (longint'(1) << (OCC_WIDTH_DEF - 1)) - 1;
  localparam longint OCC_MIN = -OCC_MAX - 1;
  localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH_DEF) - 1;
  localparam int ITEMS_PER_PHASE = 107;
  localparam int PHASES = 12;

  typedef struct packed {
    status_e            status;
    logic [END_W-1:0]   end_x;
    logic [END_W-1:0]   end_y;
    logic [WALK_W-1:0]  walked;
  } ray_result_t;

  class ray_update_board;
    int occ_cells[GRID_CELLS];
    int unsigned hit_cells[GRID_CELLS];
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
    logic signed [TRIG_W-1:0] sin_q14;
    logic signed [TRIG_W-1:0] cos_q14;
    logic [CS_W-1:0] cell_mm;
    logic [THR_W-1:0] merge_thr;
    ray_result_t expected_rays[$];
    int mismatches;

    function new();
      foreach (occ_cells[i]) begin
        occ_cells[i] = 0;
        hit_cells[i] = 0;
      end
      pose_x = '0;
      pose_y = '0;
      sin_q14 = '0;
      cos_q14 = COS_RESET;
      cell_mm = CELL_SIZE_RESET;
      merge_thr = THRESHOLD_RESET;
      mismatches = 0;
    endfunction

    function void queue_ray(ray_result_t r);
      expected_rays = {expected_rays, r};
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_POSE_X: pose_x = v[POSE_W-1:0];
        REG_POSE_Y: pose_y = v[POSE_W-1:0];
        REG_SIN: sin_q14 = v[TRIG_W-1:0];
        REG_COS: cos_q14 = v[TRIG_W-1:0];
        REG_CELL_SIZE: cell_mm = v[CS_W-1:0];
        REG_THRESHOLD: merge_thr = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint cell_of(longint mm, longint cs);
      return (longint'(GRID) * cs - 2 * mm) / (2 * cs);
    endfunction

    function longint clip_occ(longint v);
      if (v > OCC_MAX) return OCC_MAX;
      if (v < OCC_MIN) return OCC_MIN;
      return v;
    endfunction

    function void touch_cell(longint x, longint y, bit last);
      int idx;
      longint o;
      longint h;
      idx = int'(x) * GRID + int'(y);
      o = clip_occ(longint'(occ_cells[idx]) + (last ? 2 : -1));
      h = hit_cells[idx];
      if (h > longint'(merge_thr) && o < 0 && h + o > 0) o = clip_occ(o + h);
      occ_cells[idx] = int'(o);
    endfunction

    function void note_point(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y,
                             logic v);
      ray_result_t r;
      longint px, py, rx, ry, s, c, cs;
      longint ex, ey, cx, cy, dx, dy, sx, sy, ax, ay, major, minor, e, k, l, i;
      int eidx;
      bit xmaj;
      r.status = ST_UPDATED;
      r.end_x = '0;
      r.end_y = '0;
      r.walked = '0;
      if (!v) begin
        r.status = ST_INVALID;
        queue_ray(r);
        return;
      end
      px = x;
      py = y;
      rx = pose_x;
      ry = pose_y;
      s = sin_q14;
      c = cos_q14;
      cs = (cell_mm == 0) ? 1 : longint'(cell_mm);
      ex = cell_of((px * c - py * s + rx * 16384) / 16384, cs);
      ey = cell_of((px * s + py * c + ry * 16384) / 16384, cs);
      if (ex < 0 || ex >= GRID || ey < 0 || ey >= GRID) begin
        r.status = ST_END_OFF;
        queue_ray(r);
        return;
      end
      r.end_x = ex[END_W-1:0];
      r.end_y = ey[END_W-1:0];
      cx = cell_of(rx, cs);
      cy = cell_of(ry, cs);
      if (cx < 0 || cx >= GRID || cy < 0 || cy >= GRID) begin
        r.status = ST_ROBOT_OFF;
        queue_ray(r);
        return;
      end
      eidx = int'(ex) * GRID + int'(ey);
      if (longint'(hit_cells[eidx]) < COUNT_MAX) hit_cells[eidx]++;
      dx = ex - cx;
      dy = ey - cy;
      sx = (dx >= 0) ? 1 : -1;
      sy = (dy >= 0) ? 1 : -1;
      ax = dx * sx;
      ay = dy * sy;
      xmaj = ax > ay;
      major = xmaj ? ax : ay;
      minor = xmaj ? ay : ax;
      e = 0;
      k = cx;
      l = cy;
      for (i = 0; i <= major; i++) begin
        e += minor;
        if (e > major) begin
          e -= major;
          if (xmaj) l += sy;
          else k += sx;
        end
        touch_cell(k, l, i == major);
        if (xmaj) k += sx;
        else l += sy;
      end
      r.walked = WALK_W'(major + 1);
      queue_ray(r);
    endfunction

    function void check_ray(logic [STATUS_W-1:0] st, logic [END_W-1:0] ex,
                            logic [END_W-1:0] ey, logic [WALK_W-1:0] walked);
      ray_result_t want;
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ray result with none pending: status %0d end %0d,%0d walked %0d",
                   st, ex, ey, walked);
        return;
      end
      want = expected_rays.pop_front();
      if (st !== want.status || ex !== want.end_x || ey !== want.end_y ||
          walked !== want.walked) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ray mismatch: want status %0d end %0d,%0d walked %0d, got %0d %0d,%0d %0d",
                   want.status, want.end_x, want.end_y, want.walked, st, ex, ey, walked);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [POINT_W-1:0] point_x_mm_i;
  logic signed [POINT_W-1:0] point_y_mm_i;
  logic point_valid_i;
  logic cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [END_W-1:0] end_cell_x_o;
  logic [END_W-1:0] end_cell_y_o;
  logic [WALK_W-1:0] cells_walked_o;

  ray_update_board board;
  int quiet_run;

  occupancy_grid_ray_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .point_x_mm_i  (point_x_mm_i),
    .point_y_mm_i  (point_y_mm_i),
    .point_valid_i (point_valid_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .end_cell_x_o  (end_cell_x_o),
    .end_cell_y_o  (end_cell_y_o),
    .cells_walked_o(cells_walked_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check_ray(status_o, end_cell_x_o, end_cell_y_o, cells_walked_o);
  end

  task automatic write_reg(cfg_reg_e r, int value);
    while (busy || board.expected_rays.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = r;
    cfg_wdata_i = value[CFG_DATA_W-1:0];
    board.write_reg(r, value[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_config(int px, int py, int s, int c, int cs, int thr);
    write_reg(REG_POSE_X, px);
    write_reg(REG_POSE_Y, py);
    write_reg(REG_SIN, s);
    write_reg(REG_COS, c);
    write_reg(REG_CELL_SIZE, cs);
    write_reg(REG_THRESHOLD, thr);
  endtask

  // one point transfer, with a random gap before it outside quiet runs
  task automatic send_point(int x, int y, bit v);
    int gap;
    if (quiet_run > 0) begin
      quiet_run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 29) == 0) quiet_run = $urandom_range(5, 20);
    end
    repeat (gap) @(negedge clk_i);
    start = 1'b1;
    point_x_mm_i = x[POINT_W-1:0];
    point_y_mm_i = y[POINT_W-1:0];
    point_valid_i = v;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    board.note_point(point_x_mm_i, point_y_mm_i, point_valid_i);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  function automatic int pick_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_phase(int phase_no);
    int cs, reach, sel, k, n;
    int base_x[2];
    int base_y[2];
    case (phase_no)
      0: load_config(0, 0, 0, 16384, 50, 65535);
      1: load_config(1200, -800, 11585, 11585, 20, 0);
      2: load_config(-3000, 2500, 16384, 0, 100, 2);
      3: load_config(0, 0, 0, -16384, 50, 1);
      4: load_config(60, -40, -16384, 0, 1, 0);
      5: load_config(8388607, -8388608, 6000, -15000, 200, 0);
      6: load_config(100000, 0, -11585, 11585, 1000, 3);
      7: load_config(-120000, 90000, -11585, -11585, 1023, 1);
      8: load_config(0, 0, 0, 16384, 0, 0);
      default: load_config(pick_signed(20000), pick_signed(20000), pick_signed(16384),
                           pick_signed(16384), $urandom_range(1, 400),
                           $urandom_range(0, 6));
    endcase
    cs = (board.cell_mm == 0) ? 1 : int'(board.cell_mm);
    reach = cs * 127;
    if (reach > 32767) reach = 32767;
    for (k = 0; k < 2; k++) begin
      base_x[k] = pick_signed(reach / 3);
      base_y[k] = pick_signed(reach / 3);
    end
    for (n = 0; n < ITEMS_PER_PHASE; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_point($urandom, $urandom, 1'b0);
      end else if (sel < 20) begin
        send_point($urandom, $urandom, 1'b1);
      end else if (sel < 60) begin
        // points along two fixed rays, so far rays pass earlier endpoints
        k = $urandom_range(0, 1);
        send_point(base_x[k] * int'($urandom_range(1, 3)),
                   base_y[k] * int'($urandom_range(1, 3)), 1'b1);
      end else begin
        send_point(pick_signed(reach), pick_signed(reach), 1'b1);
      end
    end
  endtask

  initial begin
    int p;
    board = new();
    quiet_run = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    point_x_mm_i = '0;
    point_y_mm_i = '0;
    point_valid_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_POSE_X;
    cfg_wdata_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: robot and endpoint in one cell, field extremes, grid edges
    send_point(0, 0, 1'b1);
    send_point(-32768, 32767, 1'b0);
    send_point(32767, 0, 1'b1);
    send_point(-32768, 0, 1'b1);
    send_point(0, 32767, 1'b1);
    send_point(0, -32768, 1'b1);
    send_point(6350, 0, 1'b1);
    send_point(-6399, 0, 1'b1);
    send_point(6400, 0, 1'b1);
    send_point(6450, 0, 1'b1);
    send_point(49, 0, 1'b1);
    send_point(-49, 0, 1'b1);

    // hits folded into a cell driven negative by passing rays
    write_reg(REG_THRESHOLD, 0);
    repeat (3) send_point(500, 0, 1'b1);
    repeat (7) send_point(1000, 0, 1'b1);

    // robot off grid with the endpoint on grid
    write_reg(REG_CELL_SIZE, 1000);
    write_reg(REG_POSE_X, 130000);
    send_point(-32768, 0, 1'b1);

    // zero cell size
    write_reg(REG_POSE_X, 0);
    write_reg(REG_CELL_SIZE, 0);
    send_point(100, -50, 1'b1);

    for (p = 0; p < PHASES; p++) random_phase(p);

    while (board.expected_rays.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
